>>> rtl/pns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pns_pkg: shared types and constants of the pitch note segmenter
// Field widths, register indexes, sequencer states and divider status.
// ----------------------------------------------------------------------------
package pns_pkg;

   localparam int TIME_W   = 32;
   localparam int PITCH_W  = 15;
   localparam int SUM_W    = 31;
   localparam int COUNT_W  = 16;
   localparam int NOTE_W   = 8;
   localparam int TOL_W    = 15;
   localparam int CSR_IDX_W = 1;

   // Mean is sum / count and never exceeds the largest pitch, so it fits in
   // the pitch width; the divider produces one quotient bit per step.
   localparam int QUO_W    = PITCH_W;
   localparam int STEP_W   = 4;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   localparam logic [COUNT_W-1:0] MAX_GROUP = 16'd65535;

   localparam logic [TOL_W-1:0] GROUP_TOL_RESET = 15'd125;
   localparam logic [TOL_W-1:0] MERGE_TOL_RESET = 15'd128;

   // Half a semitone in Q7.8, used for round half up.
   localparam logic [PITCH_W:0] HALF_SEMITONE = 16'd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GROUP_TOL = 1'b0,
      REG_MERGE_TOL = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_CLOSE  = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/pitch_note_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_note_segmenter: groups timed pitch frames into notes
// Sequencer around a shared serial divider that forms each group's mean.
// ----------------------------------------------------------------------------
// Usage:
// Frames arrive on the req_ channel, one beat per frame: tdata carries the
// frame time and its Q7.8 pitch, tlast marks the end of the track. Notes leave
// on the rsp_ channel: tdata carries start time, end time and the whole
// semitone pitch, tlast is set on the final note of a track.
// A frame that opens or joins a group holds req_tready low while the
// sequencer decides on it, so such frames cannot be accepted back to back.
// A frame that closes a group holds req_tready low while the 15 steps of the
// serial divider compute the group mean and the group is closed; the note it
// releases, if any, is then offered on rsp_tvalid. An end of track beat that
// closes a group also waits for the divider, and one that finds no group open
// goes straight to the flush; both wait longer while the receiver holds off.
// A single output register holds a finished note, so the next frame can be
// accepted while a note waits for rsp_tready. When the receiver stalls and a
// second note is due, the sequencer waits in place until the register frees.
// The csr_ port writes the two tolerances; write only while the block idles.
// Synchronous reset returns the tolerances to their defaults, drops any open
// group and pending note and clears the output register.
// ----------------------------------------------------------------------------
module pitch_note_segmenter (
   input  logic                                clock,
   input  logic                                reset,
   // time_stamp [31:0], pitch [46:32]
   input  logic [pns_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // note_start [31:0], note_end [63:32], note_pitch [71:64]
   output logic [pns_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [pns_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pns_pkg::TOL_W-1:0]           csr_wdata
);
   import pns_pkg::*;

   state_type state_ff, state_in;

   // Tolerance registers.
   logic [TOL_W-1:0] gtol_ff, gtol_in;
   logic [TOL_W-1:0] mtol_ff, mtol_in;

   // Latched frame.
   logic [TIME_W-1:0]  t_ff, t_in;
   logic [PITCH_W-1:0] p_ff, p_in;
   logic               eot_ff, eot_in;

   // Group and pending note state; only the flags need reset.
   logic               open_ff, open_in;
   logic               bvalid_ff, bvalid_in;
   logic               seen_ff, seen_in;
   logic               pvalid_ff, pvalid_in;
   logic [PITCH_W-1:0] first_p_ff, first_p_in;
   logic [PITCH_W-1:0] last_p_ff, last_p_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  first_t_ff, first_t_in;
   logic [TIME_W-1:0]  last_t_ff, last_t_in;
   logic [TIME_W-1:0]  before_t_ff, before_t_in;
   logic [TIME_W-1:0]  prev_t_ff, prev_t_in;
   logic [TIME_W-1:0]  pstart_ff, pstart_in;
   logic [TIME_W-1:0]  pend_ff, pend_in;
   logic [PITCH_W-1:0] pmean_ff, pmean_in;

   // Output register.
   logic               ovalid_ff, ovalid_in;
   logic               olast_ff, olast_in;
   logic [TIME_W-1:0]  ostart_ff, ostart_in;
   logic [TIME_W-1:0]  oend_ff, oend_in;
   logic [NOTE_W-1:0]  opitch_ff, opitch_in;

   logic               div_start;
   logic [QUO_W-1:0]   mean;
   div_status_type     div_status;

   logic               req_fire;
   logic               out_free;
   logic [PITCH_W-1:0] dist_first, dist_last, dist_mean;
   logic               joins;
   logic               merge;
   logic [PITCH_W:0]   rounded;

   pns_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (mean),
      .status   (div_status)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !ovalid_ff || rsp_tready;

   always_comb begin
      dist_first = (p_ff > first_p_ff) ? p_ff - first_p_ff : first_p_ff - p_ff;
      dist_last  = (p_ff > last_p_ff) ? p_ff - last_p_ff : last_p_ff - p_ff;
      dist_mean  = (mean > pmean_ff) ? mean - pmean_ff : pmean_ff - mean;
      joins = (count_ff < MAX_GROUP) && (dist_first < gtol_ff) &&
              (dist_last < gtol_ff);
      // A closing group extends the pending note when the means are close or
      // the note ended on the frame just before the group.
      merge = pvalid_ff && ((dist_mean < mtol_ff) ||
              (bvalid_ff && (pend_ff == before_t_ff)));
      rounded = {1'b0, pmean_ff} + HALF_SEMITONE;
   end

   always_comb begin
      state_in    = state_ff;
      gtol_in     = gtol_ff;
      mtol_in     = mtol_ff;
      t_in        = t_ff;
      p_in        = p_ff;
      eot_in      = eot_ff;
      open_in     = open_ff;
      bvalid_in   = bvalid_ff;
      seen_in     = seen_ff;
      pvalid_in   = pvalid_ff;
      first_p_in  = first_p_ff;
      last_p_in   = last_p_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      first_t_in  = first_t_ff;
      last_t_in   = last_t_ff;
      before_t_in = before_t_ff;
      prev_t_in   = prev_t_ff;
      pstart_in   = pstart_ff;
      pend_in     = pend_ff;
      pmean_in    = pmean_ff;
      ovalid_in   = ovalid_ff && !rsp_tready;
      olast_in    = olast_ff;
      ostart_in   = ostart_ff;
      oend_in     = oend_ff;
      opitch_in   = opitch_ff;
      div_start   = 1'b0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_GROUP_TOL: gtol_in = csr_wdata;
            REG_MERGE_TOL: mtol_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               t_in     = req_tdata[TIME_W-1:0];
               p_in     = req_tdata[TIME_W+PITCH_W-1:TIME_W];
               eot_in   = req_tlast;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (eot_ff) begin
               if (open_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  state_in  = ST_FLUSH;
               end
            end else begin
               prev_t_in = t_ff;
               seen_in   = 1'b1;
               state_in  = ST_IDLE;
               if (!open_ff) begin
                  if (p_ff != '0) begin
                     open_in     = 1'b1;
                     first_p_in  = p_ff;
                     last_p_in   = p_ff;
                     sum_in      = SUM_W'(p_ff);
                     count_in    = COUNT_W'(1);
                     first_t_in  = t_ff;
                     last_t_in   = t_ff;
                     before_t_in = prev_t_ff;
                     bvalid_in   = seen_ff;
                  end
               end else if (joins) begin
                  last_p_in = p_ff;
                  sum_in    = sum_ff + SUM_W'(p_ff);
                  count_in  = count_ff + COUNT_W'(1);
                  last_t_in = t_ff;
               end else begin
                  // The breaking frame is dropped; only its time is kept.
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (merge) begin
               pend_in  = last_t_ff;
               open_in  = 1'b0;
               state_in = eot_ff ? ST_FLUSH : ST_IDLE;
            end else if (!pvalid_ff || out_free) begin
               if (pvalid_ff) begin
                  ovalid_in = 1'b1;
                  olast_in  = 1'b0;
                  ostart_in = pstart_ff;
                  oend_in   = pend_ff;
                  opitch_in = rounded[PITCH_W:PITCH_W-NOTE_W+1];
               end
               pvalid_in = 1'b1;
               pstart_in = first_t_ff;
               pend_in   = last_t_ff;
               pmean_in  = mean;
               open_in   = 1'b0;
               state_in  = eot_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!pvalid_ff || out_free) begin
               if (pvalid_ff) begin
                  ovalid_in = 1'b1;
                  olast_in  = 1'b1;
                  ostart_in = pstart_ff;
                  oend_in   = pend_ff;
                  opitch_in = rounded[PITCH_W:PITCH_W-NOTE_W+1];
               end
               open_in   = 1'b0;
               bvalid_in = 1'b0;
               seen_in   = 1'b0;
               pvalid_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         gtol_ff   <= GROUP_TOL_RESET;
         mtol_ff   <= MERGE_TOL_RESET;
         open_ff   <= 1'b0;
         bvalid_ff <= 1'b0;
         seen_ff   <= 1'b0;
         pvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         gtol_ff   <= gtol_in;
         mtol_ff   <= mtol_in;
         open_ff   <= open_in;
         bvalid_ff <= bvalid_in;
         seen_ff   <= seen_in;
         pvalid_ff <= pvalid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      p_ff        <= p_in;
      eot_ff      <= eot_in;
      first_p_ff  <= first_p_in;
      last_p_ff   <= last_p_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      first_t_ff  <= first_t_in;
      last_t_ff   <= last_t_in;
      before_t_ff <= before_t_in;
      prev_t_ff   <= prev_t_in;
      pstart_ff   <= pstart_in;
      pend_ff     <= pend_in;
      pmean_ff    <= pmean_in;
      olast_ff    <= olast_in;
      ostart_ff   <= ostart_in;
      oend_ff     <= oend_in;
      opitch_ff   <= opitch_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {opitch_ff, oend_ff, ostart_ff};

endmodule

>>> rtl/pns_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pns_div: serial restoring divider for the group mean
// One compare and subtract per cycle, one quotient bit per step.
// ----------------------------------------------------------------------------
module pns_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pns_pkg::SUM_W-1:0]      dividend,
   input  logic [pns_pkg::COUNT_W-1:0]    divisor,
   output logic [pns_pkg::QUO_W-1:0]      quotient,
   output pns_pkg::div_status_type        status
);
   import pns_pkg::*;

   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  dsr_ff, dsr_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   // The divisor starts aligned to the top quotient bit.
   always_comb begin
      fits    = rem_ff >= dsr_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsr_in  = SUM_W'({divisor, (QUO_W-1)'(0)});
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsr_ff;
         end
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUO_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/pns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pns_checker: port level checks for the pitch note segmenter
// Watches both channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module pns_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pns_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [pns_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [pns_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pns_pkg::TOL_W-1:0]           csr_wdata
);
   import pns_pkg::*;

   // Every accepted beat drops req_tready in the cycle after it.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // A rounded mean never goes beyond 128 semitones.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_DATA_W-NOTE_W] <= NOTE_W'(128))
      else $error("note pitch out of range");

   // Nothing is offered in the first cycle after reset.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("note offered right after reset");

   // A stalled note holds its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast))
      else $error("stalled note changed");

endmodule

bind pitch_note_segmenter pns_checker u_pns_checker (.*);

>>> sim/pitch_note_segmenter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_note_segmenter_tb: self-checking testbench of the pitch note segmenter
// Frames are driven in random bursts while the note receiver stalls on its own
// pattern. A scoreboard class predicts every note from the accepted frames,
// and each received note is compared field by field with the oldest
// prediction. A short directed run comes first. Random tracks under several
// tolerance settings follow.
// ----------------------------------------------------------------------------
module pitch_note_segmenter_tb;

   import pns_pkg::*;

   // Watchdog limit in clock cycles. The slowest legal run, with every frame
   // closing a group and the receiver stalling on every note, stays well
   // under this limit.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   // Idle cycles after the last expected note. One frame that closes a group
   // keeps the block busy while the divider runs, even when it emits nothing.
   localparam int SETTLE_CYCLES = 40;
   localparam logic [PITCH_W-1:0] TOP_PITCH = 15'h7FFF;

   // One predicted note, in the field order of rsp_tdata.
   typedef struct {
      logic [TIME_W-1:0] start_t;
      logic [TIME_W-1:0] end_t;
      logic [NOTE_W-1:0] semis;
      logic              closes;
   } note_type;

   // The scoreboard mirrors the segmenter. Each frame that the block accepts
   // updates the mirrored state, and every note that frame causes goes into
   // notes_due. Received notes must come back in the same order.
   class note_scoreboard_type;
      logic [TOL_W-1:0]   group_tol;
      logic [TOL_W-1:0]   merge_tol;
      logic               grp_active;
      logic [PITCH_W-1:0] grp_head_pitch;
      logic [PITCH_W-1:0] grp_tail_pitch;
      logic [SUM_W-1:0]   grp_total;
      logic [COUNT_W-1:0] grp_size;
      logic [TIME_W-1:0]  grp_start_t;
      logic [TIME_W-1:0]  grp_end_t;
      logic [TIME_W-1:0]  lead_t;
      logic               lead_known;
      logic [TIME_W-1:0]  prior_t;
      logic               any_frame;
      logic               held_valid;
      logic [TIME_W-1:0]  held_start;
      logic [TIME_W-1:0]  held_end;
      logic [PITCH_W-1:0] held_mean;
      note_type           notes_due[$];
      int unsigned        fail_count;

      function new();
         group_tol = GROUP_TOL_RESET;
         merge_tol = MERGE_TOL_RESET;
         fail_count = 0;
         clear_track();
      endfunction

      function void clear_track();
         grp_active = 1'b0;
         grp_head_pitch = '0;
         grp_tail_pitch = '0;
         grp_total = '0;
         grp_size = '0;
         grp_start_t = '0;
         grp_end_t = '0;
         lead_t = '0;
         lead_known = 1'b0;
         prior_t = '0;
         any_frame = 1'b0;
         held_valid = 1'b0;
         held_start = '0;
         held_end = '0;
         held_mean = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [TOL_W-1:0] value);
         case (idx)
            REG_GROUP_TOL: group_tol = value;
            REG_MERGE_TOL: merge_tol = value;
            default: ;
         endcase
      endfunction

      function logic [PITCH_W-1:0] pitch_gap(logic [PITCH_W-1:0] a, logic [PITCH_W-1:0] b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void emit(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                         logic [PITCH_W-1:0] mean, logic closes);
         note_type    n;
         logic [15:0] rounded;
         rounded = {1'b0, mean} + HALF_SEMITONE;
         n.start_t = s;
         n.end_t = e;
         n.semis = rounded[15:8];
         n.closes = closes;
         notes_due.insert(notes_due.size(), n);
      endfunction

      function void close_group();
         logic [PITCH_W-1:0] mean;
         logic               merge;
         mean = '0;
         if (grp_size != 0)
            mean = PITCH_W'(grp_total / grp_size);
         merge = held_valid && ((pitch_gap(mean, held_mean) < merge_tol) ||
                                (lead_known && held_end == lead_t));
         if (merge) begin
            held_end = grp_end_t;
         end else begin
            if (held_valid)
               emit(held_start, held_end, held_mean, 1'b0);
            held_valid = 1'b1;
            held_start = grp_start_t;
            held_end = grp_end_t;
            held_mean = mean;
         end
         grp_active = 1'b0;
         grp_total = '0;
         grp_size = '0;
      endfunction

      // Called at the edge where a frame beat is accepted.
      function void note_frame(logic [TIME_W-1:0] t, logic [PITCH_W-1:0] p, logic eot);
         if (eot) begin
            if (grp_active)
               close_group();
            if (held_valid)
               emit(held_start, held_end, held_mean, 1'b1);
            clear_track();
            return;
         end
         if (!grp_active) begin
            // Unvoiced frames are skipped while no group is open.
            if (p != 0) begin
               grp_active = 1'b1;
               grp_head_pitch = p;
               grp_tail_pitch = p;
               grp_total = SUM_W'(p);
               grp_size = COUNT_W'(1);
               grp_start_t = t;
               grp_end_t = t;
               lead_t = prior_t;
               lead_known = any_frame;
            end
         end else if (grp_size < MAX_GROUP &&
                      pitch_gap(grp_head_pitch, p) < group_tol &&
                      pitch_gap(grp_tail_pitch, p) < group_tol) begin
            grp_tail_pitch = p;
            grp_total = grp_total + SUM_W'(p);
            grp_size = grp_size + COUNT_W'(1);
            grp_end_t = t;
         end else begin
            // The breaking frame closes the group and is itself dropped.
            close_group();
         end
         prior_t = t;
         any_frame = 1'b1;
      endfunction

      // Called at the edge where a note beat is accepted.
      function void check_note(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                               logic [NOTE_W-1:0] semis, logic closes);
         note_type n;
         if (notes_due.size() == 0) begin
            $error("unexpected note: note_start %0d note_end %0d note_pitch %0d last %0b",
                   s, e, semis, closes);
            fail_count++;
            return;
         end
         n = notes_due.pop_front();
         if (s !== n.start_t) begin
            $error("note_start: expected %0d, actual %0d", n.start_t, s);
            fail_count++;
         end
         if (e !== n.end_t) begin
            $error("note_end: expected %0d, actual %0d", n.end_t, e);
            fail_count++;
         end
         if (semis !== n.semis) begin
            $error("note_pitch: expected %0d, actual %0d", n.semis, semis);
            fail_count++;
         end
         if (closes !== n.closes) begin
            $error("last: expected %0b, actual %0b", n.closes, closes);
            fail_count++;
         end
      endfunction

      function int unsigned outstanding();
         return notes_due.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   // time_stamp [31:0], pitch [46:32], bit 47 is zero
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // note_start [31:0], note_end [63:32], note_pitch [71:64]
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [TOL_W-1:0]       csr_wdata = '0;

   note_scoreboard_type sb = new();

   // Sender and stimulus state.
   int          burst_left = 0;
   logic [31:0] cur_t = '0;
   int          base_p = 6000;
   int          cur_gt = GROUP_TOL_RESET;
   int          cur_mt = MERGE_TOL_RESET;

   // Receiver state.
   int          rx_mode = 0;
   int          rx_mode_left = 0;
   int          rx_stall_left = 0;
   logic        rx_ready_next;

   int unsigned cycle_count = 0;

   pitch_note_segmenter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog. A run that hangs on a handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Note receiver. Outputs are sampled at the edge before any update lands, so
   // a note beat counts exactly when rsp_tvalid and rsp_tready were both high.
   // The ready pattern switches at random among three modes: always ready,
   // randomly ready, or mostly ready with long stalls.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_note(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[71:64], rsp_tlast);
      if (rx_mode_left == 0) begin
         rx_mode <= $urandom_range(0, 2);
         rx_mode_left <= $urandom_range(50, 400);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         0: rx_ready_next = 1'b1;
         1: rx_ready_next = ($urandom_range(0, 9) < 6);
         default: begin
            if (rx_stall_left != 0) begin
               rx_ready_next = 1'b0;
               rx_stall_left <= rx_stall_left - 1;
            end else begin
               rx_ready_next = 1'b1;
               if ($urandom_range(0, 7) == 0)
                  rx_stall_left <= $urandom_range(5, 30);
            end
         end
      endcase
      rsp_tready <= reset ? 1'b0 : rx_ready_next;
   end

   // Both tolerances are written back to back on consecutive edges, so csr_we
   // stays high across the pair and is lowered only once.
   task automatic set_tolerances(input logic [TOL_W-1:0] gt, input logic [TOL_W-1:0] mt);
      csr_we <= 1'b1;
      csr_index <= REG_GROUP_TOL;
      csr_wdata <= gt;
      @(posedge clock);
      csr_index <= REG_MERGE_TOL;
      csr_wdata <= mt;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(REG_GROUP_TOL, gt);
      sb.write_reg(REG_MERGE_TOL, mt);
      cur_gt = gt;
      cur_mt = mt;
   endtask

   // Drives one frame beat and waits for its acceptance. Between bursts the
   // sender may drop req_tvalid for a random gap; within a burst req_tvalid stays
   // high and the next beat is driven at the edge that accepted the last one.
   task automatic send_beat(input logic [31:0] t, input logic [PITCH_W-1:0] p,
                            input logic eot);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left != 0)
         burst_left--;
      req_tdata <= {1'b0, p, t};
      req_tlast <= eot;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_frame(t, p, eot);
   endtask

   // Holds the sender off until every predicted note has been received, then
   // lets the block finish any group close that emits nothing.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_time();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         cur_t = cur_t + $urandom_range(1, 3);
      else if (r < 88)
         cur_t = cur_t;          // repeated time lets the time-based merge fire
      else if (r < 95)
         cur_t = $urandom;
      else
         cur_t = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      return cur_t;
   endfunction

   function automatic int clamp_pitch(int v);
      if (v < 0)
         return 0;
      if (v > 32767)
         return 32767;
      return v;
   endfunction

   // Voiced runs around a base pitch with jitter inside the join tolerance,
   // broken up by unvoiced frames, jumps just past the tolerance, new notes
   // near or far from the last one, and fully random pitches.
   function automatic logic [PITCH_W-1:0] pick_pitch();
      int r;
      int j;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      if (r < 18) begin
         if ($urandom_range(0, 9) < 4)
            base_p = clamp_pitch(base_p + int'($urandom_range(0, 2 * cur_mt)) - cur_mt);
         else if ($urandom_range(0, 9) == 0)
            base_p = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 255)
                                                 : $urandom_range(32512, 32767);
         else
            base_p = $urandom_range(256, 32767);
         return PITCH_W'(base_p);
      end
      if (r < 22)
         return PITCH_W'($urandom);
      if (r < 27) begin
         j = cur_gt + int'($urandom_range(0, 3));
         return PITCH_W'(clamp_pitch(($urandom_range(0, 1) == 0) ? base_p + j : base_p - j));
      end
      j = cur_gt / 3;
      if (j > 3000)
         j = 3000;
      return PITCH_W'(clamp_pitch(base_p + int'($urandom_range(0, 2 * j)) - j));
   endfunction

   // A random track of n items. End of track beats are sprinkled in at a low
   // rate; their time and pitch fields carry random values that must be ignored.
   // When pause_at matches an item index, the sender waits for every note first.
   task automatic run_track(input int n, input int pause_at);
      logic [31:0]        t;
      logic [PITCH_W-1:0] p;
      for (int i = 0; i < n; i++) begin
         if (i == pause_at)
            drain();
         if ($urandom_range(0, 99) < 3) begin
            send_beat($urandom, PITCH_W'($urandom), 1'b1);
         end else begin
            t = pick_time();
            p = pick_pitch();
            send_beat(t, p, 1'b0);
         end
      end
      send_beat($urandom, PITCH_W'($urandom), 1'b1);
      drain();
   endtask

   // Directed run under the reset tolerances (join below 125, merge below 128).
   task automatic run_directed();
      send_beat(32'd0, 15'd0, 1'b1);                 // end of track with nothing open
      send_beat(32'd5, 15'd0, 1'b0);                 // unvoiced frame, no group
      send_beat(32'd6, TOP_PITCH, 1'b0);             // opens on the first voiced frame
      send_beat(32'd7, TOP_PITCH - 15'd124, 1'b0);   // just inside the tolerance
      // Just outside the first pitch, and at a repeated time.
      send_beat(32'd7, TOP_PITCH - 15'd125, 1'b0);
      send_beat(32'd8, 15'd1, 1'b0);                 // frame before it equals the note end
      send_beat(32'd9, 15'd0, 1'b0);                 // unvoiced frame joins an open group
      send_beat(32'd10, 15'd126, 1'b0);              // breaks; merged by time
      send_beat(32'd11, 15'd0, 1'b0);
      send_beat(32'd12, 15'd200, 1'b0);
      send_beat(32'd13, 15'd250, 1'b0);
      send_beat(32'd14, 15'd5000, 1'b0);             // breaks; pending note goes out
      send_beat(32'd20, 15'd300, 1'b0);
      send_beat(32'hFFFF_FFFF, 15'd310, 1'b0);
      send_beat(32'd0, 15'd0, 1'b0);                 // breaks; merged by mean
      send_beat(32'd1, 15'h4000, 1'b1);              // flush of one note, fields ignored
      send_beat(32'd30, TOP_PITCH, 1'b0);            // first frame of a new track
      send_beat(32'd31, TOP_PITCH, 1'b0);
      send_beat(32'd32, 15'd100, 1'b0);
      send_beat(32'd33, 15'd1000, 1'b0);
      send_beat(32'd34, 15'h5555, 1'b1);             // closes a group: two notes
      send_beat(32'd40, 15'h2AAA, 1'b0);
      send_beat(32'hAAAA_5555, 15'h2AAA, 1'b1);
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_track(200, 100);

      // The extremes of both tolerances: nothing joins and nothing merges by
      // mean, then almost everything does.
      set_tolerances(15'd0, 15'd0);
      run_track(120, -1);
      set_tolerances(15'h7FFF, 15'h7FFF);
      run_track(120, -1);

      set_tolerances(15'd0, 15'h7FFF);
      run_track(120, -1);
      set_tolerances(15'h7FFF, 15'd0);
      run_track(120, -1);
      for (int k = 0; k < 3; k++) begin
         set_tolerances(TOL_W'($urandom_range(40, 600)), TOL_W'($urandom_range(40, 600)));
         run_track(120, -1);
      end
      set_tolerances(15'd2, 15'd5);
      run_track(120, -1);

      if (sb.fail_count == 0 && sb.outstanding() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
